[rtl/bitmap_block_allocator_defines.svh]
// Assertion macros for the bitmap block allocator.
// Used by the top level only; expects clk and rst in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// condition holds at every edge out of reset
`define BBA_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BBA_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BBA_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
// No dependencies; used by bba_word_unit and bitmap_block_allocator.
package bba_pkg;

  localparam int MAP_WORDS_DEF = 1024;
  // block size in bytes; a power of two so that the block number is a shift
  localparam int BLOCK_BYTES   = 4096;
  localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int ABW           = 32 - BLOCK_SHIFT;
  localparam int TOTAL_RESET   = 32768;
  localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ALLOC     = 2'd0,
    KIND_FREE      = 2'd1,
    KIND_MARK_USED = 2'd2,
    KIND_MARK_FREE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESP
  } state_t;

  // one read-modify-write on a map word: cnt bits from bit lo upward
  typedef struct packed {
    logic       set;
    logic [4:0] lo;
    logic [5:0] cnt;
  } word_op_t;

endpackage

[rtl/bitmap_block_allocator.sv]
// Bitmap block allocator, first fit, with a single-port usage map memory.
// Depends on bba_pkg, bba_word_unit and bitmap_block_allocator_defines.svh.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tuser: kind, tdata: address, length
//   m_axis    out        m_axis_tvalid/tready       tdata: block_address, ok, free, used
//   cfg       in         cfg_we (no wait)           cfg_wdata: total_blocks
//
// One item at a time; each kind walks the states below to ST_RESP.
// Allocate: straight to ST_RESP when nothing is free or no whole word is managed,
// else ST_SCAN_RD and ST_SCAN_CHK per map word, then ST_MARK_WR when a clear bit is found.
// Free and region requests: ST_SETUP, then ST_MARK_RD and ST_MARK_WR per map word in the clipped block run.
// Reset and every cfg write refill the map with ones, one word a cycle, with no
// item taken; a stalled m_axis holds ST_RESP.
`include "bitmap_block_allocator_defines.svh"

module bitmap_block_allocator #(
  parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] address, [63:32] length
  input  logic  [1:0] s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] block_address, [32] ok,
                                      // [48:33] free_count, [64:49] used_count
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata       // total_blocks
);

  localparam int WORD_AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CAP     = MAP_WORDS * 32;
  localparam logic [15:0] TOT_RESET =
    16'((bba_pkg::TOTAL_RESET < CAP) ? bba_pkg::TOTAL_RESET : CAP);
  localparam int ABW = bba_pkg::ABW;

  // ---------------------------------------------------------------------
  // State and registers
  // ---------------------------------------------------------------------
  bba_pkg::state_t state, state_next;

  logic [15:0]         tot;          // managed total, already clipped
  logic [15:0]         free_cnt;
  logic [15:0]         used_cnt;
  logic [WORD_AW-1:0]  clr_idx;
  logic [10:0]         scan_w;

  logic                op_set;       // 1: mark used, 0: mark free
  logic                ok_r;
  logic [31:0]         addr_r;
  logic [ABW-1:0]      start_r;
  logic [ABW-1:0]      lenb_r;
  logic [15:0]         cur;          // next block to mark
  logic [15:0]         end_c;        // one past the last block to mark
  logic [15:0]         wend_r;       // end of the current word's run
  logic [5:0]          n_r;          // blocks in the current word's run

  logic                out_valid;
  logic [71:0]         out_data;

  // memory
  logic [31:0]         map [MAP_WORDS];
  logic [31:0]         mem_rdata;
  logic [31:0]         mem_wdata;
  logic [WORD_AW-1:0]  mem_addr;
  logic                mem_re;
  logic                mem_we;

  // ---------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------
  logic [15:0]         cfg_tot;
  logic                in_fire;
  bba_pkg::kind_t      in_kind;
  logic                alloc_fail_now;
  logic [31:0]         start32;
  logic [32:0]         end_full;
  logic                setup_go;
  logic [15:0]         end_clip;
  logic                scan_last;
  logic [15:0]         found_blk;
  logic [47:0]         found_addr;
  logic [16:0]         seg_end;
  logic [15:0]         wend;
  logic [15:0]         n_full;
  logic                mark_done;
  logic [16:0]         used_sum;
  logic [16:0]         free_sum;
  logic [31:0]         scan_w32;
  logic [31:0]         cur_w32;
  logic                resp_load;

  bba_pkg::word_op_t   wop;
  logic [31:0]         new_word;
  logic                clr_found;
  logic [4:0]          clr_bit;

  assign cfg_tot  = ({16'd0, cfg_wdata} < 32'(CAP)) ? cfg_wdata : 16'(CAP);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_kind  = bba_pkg::kind_t'(s_axis_tuser);

  // allocation fails at once when nothing is free or no whole word is managed
  assign alloc_fail_now = (free_cnt == 16'd0) || (tot[15:5] == 11'd0);

  assign start32  = 32'(start_r);
  assign end_full = 33'(start_r) + 33'(lenb_r);
  assign setup_go = (start32 < 32'(tot)) && (lenb_r != '0);
  assign end_clip = (end_full > 33'(tot)) ? tot : end_full[15:0];

  assign scan_last  = (({1'b0, scan_w} + 12'd1) == {1'b0, tot[15:5]});
  assign found_blk  = {scan_w, clr_bit};
  assign found_addr = 48'(found_blk) << bba_pkg::BLOCK_SHIFT;

  // run in the current word ends at the word boundary or at the clipped end
  assign seg_end = 17'({cur[15:5], 5'd0}) + 17'd32;
  assign wend    = (seg_end > 17'(end_c)) ? end_c : seg_end[15:0];
  assign n_full  = wend - cur;

  assign mark_done = (wend_r == end_c);
  assign used_sum  = 17'(used_cnt) + 17'(n_r);
  assign free_sum  = 17'(free_cnt) + 17'(n_r);

  assign scan_w32  = 32'(scan_w);
  assign cur_w32   = 32'(cur[15:5]);

  assign resp_load = (state == bba_pkg::ST_RESP) && (!out_valid || m_axis_tready);

  assign wop.set = op_set;
  assign wop.lo  = cur[4:0];
  assign wop.cnt = n_r;

  bba_word_unit u_word (
    .word      (mem_rdata),
    .op        (wop),
    .new_word  (new_word),
    .clr_found (clr_found),
    .clr_bit   (clr_bit)
  );

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == bba_pkg::KIND_ALLOC) begin
            state_next = alloc_fail_now ? bba_pkg::ST_RESP : bba_pkg::ST_SCAN_RD;
          end else begin
            state_next = bba_pkg::ST_SETUP;
          end
        end
      end
      bba_pkg::ST_CLEAR: begin
        if (clr_idx == WORD_AW'(MAP_WORDS - 1)) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_SETUP: begin
        state_next = setup_go ? bba_pkg::ST_MARK_RD : bba_pkg::ST_RESP;
      end
      bba_pkg::ST_SCAN_RD: begin
        state_next = bba_pkg::ST_SCAN_CHK;
      end
      bba_pkg::ST_SCAN_CHK: begin
        if (clr_found) begin
          state_next = bba_pkg::ST_MARK_WR;
        end else if (scan_last) begin
          state_next = bba_pkg::ST_RESP;
        end else begin
          state_next = bba_pkg::ST_SCAN_RD;
        end
      end
      bba_pkg::ST_MARK_RD: begin
        state_next = bba_pkg::ST_MARK_WR;
      end
      bba_pkg::ST_MARK_WR: begin
        state_next = mark_done ? bba_pkg::ST_RESP : bba_pkg::ST_MARK_RD;
      end
      bba_pkg::ST_RESP: begin
        if (resp_load) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::ST_IDLE;
      end
    endcase
    // a register write restarts the allocator with a fresh map
    if (cfg_we) begin
      state_next = bba_pkg::ST_CLEAR;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (memory port, input ready)
  // ---------------------------------------------------------------------
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cur_w32[WORD_AW-1:0];
    mem_wdata = new_word;
    case (state)
      bba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx;
        mem_wdata = bba_pkg::FULL_WORD;
      end
      bba_pkg::ST_SCAN_RD: begin
        mem_re   = 1'b1;
        mem_addr = scan_w32[WORD_AW-1:0];
      end
      bba_pkg::ST_MARK_RD: begin
        mem_re = 1'b1;
      end
      bba_pkg::ST_MARK_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = (state == bba_pkg::ST_IDLE) && !cfg_we;

  // ---------------------------------------------------------------------
  // Usage map memory: one port, registered read
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= map[mem_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::ST_CLEAR;
      clr_idx   <= '0;
      tot       <= TOT_RESET;
      free_cnt  <= 16'd0;
      used_cnt  <= TOT_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        tot      <= cfg_tot;
        free_cnt <= 16'd0;
        used_cnt <= cfg_tot;
        clr_idx  <= '0;
      end else begin
        if (state == bba_pkg::ST_CLEAR) begin
          clr_idx <= clr_idx + WORD_AW'(1);
        end

        // move the counters by the whole run, saturating at 0 and at total
        if (state == bba_pkg::ST_MARK_WR) begin
          if (op_set) begin
            used_cnt <= (used_sum > 17'(tot)) ? tot : used_sum[15:0];
            free_cnt <= (free_cnt >= 16'(n_r)) ? (free_cnt - 16'(n_r)) : 16'd0;
          end else begin
            free_cnt <= (free_sum > 17'(tot)) ? tot : free_sum[15:0];
            used_cnt <= (used_cnt >= 16'(n_r)) ? (used_cnt - 16'(n_r)) : 16'd0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      bba_pkg::ST_IDLE: begin
        if (in_fire) begin
          ok_r    <= !((in_kind == bba_pkg::KIND_ALLOC) && alloc_fail_now);
          addr_r  <= 32'd0;
          op_set  <= (in_kind == bba_pkg::KIND_ALLOC) ||
                     (in_kind == bba_pkg::KIND_MARK_USED);
          scan_w  <= 11'd0;
          start_r <= s_axis_tdata[31:bba_pkg::BLOCK_SHIFT];
          // a single free is a run of one block
          lenb_r  <= (in_kind == bba_pkg::KIND_FREE) ? ABW'(1)
                                                     : s_axis_tdata[63:32+bba_pkg::BLOCK_SHIFT];
        end
      end
      bba_pkg::ST_SETUP: begin
        cur   <= start32[15:0];
        end_c <= end_clip;
      end
      bba_pkg::ST_SCAN_CHK: begin
        if (clr_found) begin
          // mark the found block straight from the word just read
          cur    <= found_blk;
          end_c  <= found_blk + 16'd1;
          wend_r <= found_blk + 16'd1;
          n_r    <= 6'd1;
          addr_r <= found_addr[31:0];
        end else if (scan_last) begin
          ok_r <= 1'b0;
        end else begin
          scan_w <= scan_w + 11'd1;
        end
      end
      bba_pkg::ST_MARK_RD: begin
        wend_r <= wend;
        n_r    <= n_full[5:0];
      end
      bba_pkg::ST_MARK_WR: begin
        cur <= wend_r;
      end
      bba_pkg::ST_RESP: begin
        if (resp_load) begin
          out_data <= {7'd0, used_cnt, free_cnt, ok_r, addr_r};
        end
      end
      default: begin
        ok_r <= ok_r;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BBA_HOLDS(a_cnt_sum, (17'(free_cnt) + 17'(used_cnt)) <= 17'(tot), "free plus used exceeds the managed total")
  `BBA_IMPLIES(a_run_len, state == bba_pkg::ST_MARK_WR, (n_r != 6'd0) && (n_r <= 6'd32), "word run length out of range")
  `BBA_IMPLIES(a_fail_addr, m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0, "failed allocation with nonzero address")
  `BBA_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while one is in progress")

endmodule

[rtl/bba_word_unit.sv]
// Word unit of the bitmap block allocator: masks a run of bits in a map
// word and finds the lowest clear bit. Depends on bba_pkg.
module bba_word_unit (
  input  logic              [31:0] word,
  input  bba_pkg::word_op_t        op,
  output logic              [31:0] new_word,
  output logic                     clr_found,
  output logic               [4:0] clr_bit
);

  logic [5:0]  hi;
  logic [31:0] mask;

  assign hi = {1'b0, op.lo} + op.cnt;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      mask[i] = (6'(i) >= {1'b0, op.lo}) && (6'(i) < hi);
    end
  end

  assign new_word = op.set ? (word | mask) : (word & ~mask);

  // lowest clear bit wins
  always_comb begin
    clr_bit = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!word[i]) begin
        clr_bit = 5'(i);
      end
    end
  end

  assign clr_found = (word != bba_pkg::FULL_WORD);

endmodule

[dv/bitmap_block_allocator_tb.sv]
// Self-checking testbench for the first-fit bitmap block allocator.
// Depends on bba_pkg and the bitmap_block_allocator top level; the block
// allocator's usage map and counters are mirrored by a scoreboard class.
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;

  localparam int MAP_WORDS   = bba_pkg::MAP_WORDS_DEF;
  localparam int MAP_BLOCKS  = MAP_WORDS * 32;
  localparam int STALL_LIMIT = 20000;  // cycles with no item moving on either side
  localparam int N_PHASES    = 10;

  // result item as it sits on m_axis_tdata, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] used_count;
    logic [15:0] free_count;
    logic        ok;
    logic [31:0] block_address;
  } alloc_result_t;

  // Mirror of the usage map and counters, plus the queue of results owed.
  class alloc_scoreboard;
    logic [31:0]   usage_bits [MAP_WORDS];
    int unsigned   free_cnt;
    int unsigned   used_cnt;
    int unsigned   managed;
    alloc_result_t owed_q [$];
    int            errors;

    // a register write clips the total and marks every block used
    function void restart(input logic [15:0] total_reg);
      managed = (total_reg < MAP_BLOCKS) ? total_reg : MAP_BLOCKS;
      foreach (usage_bits[w]) usage_bits[w] = bba_pkg::FULL_WORD;
      free_cnt = 0;
      used_cnt = managed;
    endfunction

    // counters move by one even when the bit already held the target state
    function void mark_block(input int unsigned blk, input bit make_used);
      if (make_used) begin
        usage_bits[blk >> 5][blk & 31] = 1'b1;
        if (used_cnt < managed) used_cnt++;
        if (free_cnt > 0) free_cnt--;
      end else begin
        usage_bits[blk >> 5][blk & 31] = 1'b0;
        if (free_cnt < managed) free_cnt++;
        if (used_cnt > 0) used_cnt--;
      end
    endfunction

    function void note_request(input bba_pkg::kind_t kind, input logic [31:0] addr,
                               input logic [31:0] len);
      alloc_result_t     res;
      longint unsigned   first;
      longint unsigned   last;
      int unsigned       found_blk;
      bit                found;
      res = '0;
      res.ok = 1'b1;
      found = 1'b0;
      found_blk = 0;
      first = {32'd0, addr} >> bba_pkg::BLOCK_SHIFT;
      case (kind)
        bba_pkg::KIND_ALLOC: begin
          // an empty free count fails at once; otherwise search managed/32 words
          if (free_cnt != 0) begin
            for (int w = 0; w < managed / 32 && !found; w++) begin
              if (usage_bits[w] != bba_pkg::FULL_WORD) begin
                for (int b = 0; b < 32 && !found; b++) begin
                  if (!usage_bits[w][b]) begin
                    found = 1'b1;
                    found_blk = w * 32 + b;
                  end
                end
              end
            end
          end
          if (found) begin
            mark_block(found_blk, 1'b1);
            res.block_address = found_blk * bba_pkg::BLOCK_BYTES;
          end else begin
            res.ok = 1'b0;
          end
        end
        bba_pkg::KIND_FREE: begin
          if (first < managed) mark_block(32'(first), 1'b0);
        end
        default: begin
          // region walk upward from the base block, clipped at the managed total
          last = first + ({32'd0, len} >> bba_pkg::BLOCK_SHIFT);
          if (last > managed) last = managed;
          for (longint unsigned b = first; b < last; b++)
            mark_block(32'(b), kind == bba_pkg::KIND_MARK_USED);
        end
      endcase
      res.free_count = 16'(free_cnt);
      res.used_count = 16'(used_cnt);
      owed_q.push_back(res);
    endfunction

    function void check_result(input logic [71:0] data);
      alloc_result_t got;
      alloc_result_t want;
      got = data;
      if (owed_q.size() == 0) begin
        $error("result item with none owed: %h", data);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.block_address !== want.block_address) begin
        $error("block_address: expected %h, got %h", want.block_address, got.block_address);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
        errors++;
      end
      if (got.used_count !== want.used_count) begin
        $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = bba_pkg::KIND_ALLOC;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_we        = 1'b0;
  logic [15:0] cfg_wdata     = '0;

  alloc_scoreboard sb = new();

  // idling odds in percent, set per phase
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int quiet_cycles  = 0;

  // register settings per phase: both extremes, tiny maps and a partial last word
  logic [15:0] phase_total [N_PHASES] = '{16'd0, 16'd1, 16'd33, 16'd64, 16'd100,
                                          16'd65535, 16'd32, 16'd200, 16'd96, 16'd31};
  int          phase_items [N_PHASES] = '{15, 20, 50, 50, 60, 40, 50, 60, 50, 30};

  bitmap_block_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sink: stall at random with the odds of the current phase.
  always @(posedge clk) m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);

  // Observe both handshakes at the edge; values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(bba_pkg::kind_t'(s_axis_tuser), s_axis_tdata[31:0],
                        s_axis_tdata[63:32]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
    end
  end

  // Watchdog: give up when no item has moved for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item; hold it until accepted. Gaps drop tvalid while a random draw falls under the idle odds.
  task automatic send_item(input bba_pkg::kind_t kind, input logic [31:0] addr,
                           input logic [31:0] len);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, addr};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Random request, mostly aimed inside the managed map.
  task automatic send_random();
    int unsigned    tot;
    int unsigned    span;
    int unsigned    pick;
    bba_pkg::kind_t kind;
    logic [31:0]    addr;
    logic [31:0]    len;
    tot  = sb.managed;
    span = (tot <= 256) ? tot / 2 + 2 : 48;
    pick = $urandom_range(99, 0);
    kind = (pick < 40) ? bba_pkg::KIND_ALLOC : (pick < 60) ? bba_pkg::KIND_FREE :
           (pick < 75) ? bba_pkg::KIND_MARK_USED : bba_pkg::KIND_MARK_FREE;
    if ($urandom_range(9, 0) == 0)
      addr = $urandom;
    else
      addr = ($urandom_range(tot + 2, 0) << bba_pkg::BLOCK_SHIFT) |
             $urandom_range(bba_pkg::BLOCK_BYTES - 1, 0);
    pick = $urandom_range(99, 0);
    if (pick < 5)
      len = $urandom;
    else if (pick < 10)
      len = $urandom_range(bba_pkg::BLOCK_BYTES - 1, 0);
    else
      len = ($urandom_range(span, 1) << bba_pkg::BLOCK_SHIFT) |
            $urandom_range(bba_pkg::BLOCK_BYTES - 1, 0);
    send_item(kind, addr, len);
  endtask

  // Drain, pause, then rewrite the total; the block refills its map afterwards.
  task automatic write_total(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.restart(value);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1:       begin src_idle_pct = 88; sink_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  sink_stall_pct = 88; end
      default: begin src_idle_pct = 30; sink_stall_pct = 30; end
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    sb.restart(16'(bba_pkg::TOTAL_RESET));
    set_idling(0);

    // Directed part on the reset total: empty free count, single blocks,
    // out-of-range blocks, short regions, repeats and both saturations.
    send_item(bba_pkg::KIND_ALLOC,     32'h0000_0000, 32'h0000_0000);  // fails, nothing free
    send_item(bba_pkg::KIND_FREE,      32'h0000_0000, 32'h0000_0000);
    send_item(bba_pkg::KIND_ALLOC,     32'hFFFF_FFFF, 32'hFFFF_FFFF);  // takes block 0
    send_item(bba_pkg::KIND_ALLOC,     32'h0000_0000, 32'h0000_0000);
    send_item(bba_pkg::KIND_MARK_FREE, 32'h0000_5123, 32'h0000_3064);  // blocks 5 to 7
    send_item(bba_pkg::KIND_ALLOC,     32'h0000_0000, 32'h0000_0000);
    send_item(bba_pkg::KIND_FREE,      32'hFFFF_FFFF, 32'h0000_0000);  // past the map end
    send_item(bba_pkg::KIND_MARK_USED, 32'hFFFF_F000, 32'hFFFF_FFFF);  // starts past the end
    send_item(bba_pkg::KIND_MARK_FREE, 32'h0000_2000, 32'h0000_0FFF);  // under one block
    send_item(bba_pkg::KIND_FREE,      32'h0000_6000, 32'h0000_0000);  // already free
    send_item(bba_pkg::KIND_MARK_USED, 32'h0000_0000, 32'h0000_1000);  // already used
    send_item(bba_pkg::KIND_MARK_FREE, 32'h07FF_F000, 32'h0000_3000);  // clipped to last block
    send_item(bba_pkg::KIND_MARK_FREE, 32'h0000_0000, 32'hFFFF_FFFF);  // whole map free
    send_item(bba_pkg::KIND_FREE,      32'h0000_0FFF, 32'h0000_0000);  // free count saturates
    send_item(bba_pkg::KIND_ALLOC,     32'h0000_0000, 32'h0000_0000);
    send_item(bba_pkg::KIND_MARK_USED, 32'h0000_0000, 32'hFFFF_FFFF);  // whole map used
    send_item(bba_pkg::KIND_MARK_USED, 32'h0000_3000, 32'h0000_1000);  // used count saturates
    send_item(bba_pkg::KIND_FREE,      32'h0000_1000, 32'h0000_0000);
    send_item(bba_pkg::KIND_FREE,      32'h0000_1000, 32'h0000_0000);  // free count 2, one bit
    send_item(bba_pkg::KIND_ALLOC,     32'h0000_0000, 32'h0000_0000);
    send_item(bba_pkg::KIND_ALLOC,     32'h0000_0000, 32'h0000_0000);  // no clear bit left
    repeat (10) send_random();

    for (int p = 0; p < N_PHASES; p++) begin
      write_total(phase_total[p]);
      set_idling((p + 1) % 4);
      repeat (phase_items[p]) send_random();
    end

    // Drop valid, wait for the last results, then a short tail for strays.
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
